@@ design/top_k_lowest_score_keeper_core_defines.svh @@
// assertion macros for the top-k lowest score keeper
// used by the port checker; needs signals named clock and reset in scope
`ifndef TOP_K_LOWEST_SCORE_KEEPER_CORE_DEFINES_SVH
`define TOP_K_LOWEST_SCORE_KEEPER_CORE_DEFINES_SVH

`define TKK_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tkk check failed");

`define TKK_ASSERT_NOW(label, cond, prop) `TKK_ASSERT(label, (cond) |-> (prop))

`define TKK_ASSERT_NEXT(label, cond, prop) `TKK_ASSERT(label, (cond) |=> (prop))

`endif

@@ design/tkk_pkg.sv @@
// shared types and constants of the top-k lowest score keeper
// no dependencies
`default_nettype none

package tkk_pkg;

   localparam int MAX_ENTRIES_DEF   = 16;
   localparam int SCORE_WIDTH_DEF   = 32;
   localparam int PAYLOAD_WIDTH_DEF = 32;

   localparam int IDX_W      = 4;
   localparam int CAP_W      = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // word index of the capacity register
   localparam logic [0:0] REG_CAPACITY = 1'b0;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_READ   = 1'b1
   } opcode_type;

   typedef struct packed {
      logic fire;
      logic is_read;
   } store_ctl_type;

   typedef struct packed {
      logic kept;
      logic read_valid;
   } store_sts_type;

endpackage

`default_nettype wire

@@ design/top_k_lowest_score_keeper_core.sv @@
// result: an accepted item's result is in the output register in the next cycle
// throughput: one item per cycle while the result side is ready; every slot compares
// and shifts in parallel, so the store update never holds the flow
// reset: entry count to zero, capacity to 16, result side empty; store contents undefined
// depends on tkk_pkg and tkk_store
`default_nettype none

module top_k_lowest_score_keeper_core #(
   parameter int MAX_ENTRIES   = tkk_pkg::MAX_ENTRIES_DEF,
   parameter int SCORE_WIDTH   = tkk_pkg::SCORE_WIDTH_DEF,
   parameter int PAYLOAD_WIDTH = tkk_pkg::PAYLOAD_WIDTH_DEF,
   localparam int CNT_W        = $clog2(MAX_ENTRIES + 1),
   localparam int REQ_RAW_W    = PAYLOAD_WIDTH + SCORE_WIDTH + tkk_pkg::IDX_W,
   localparam int REQ_TDATA_W  = ((REQ_RAW_W + 7) / 8) * 8,
   localparam int RSP_RAW_W    = CNT_W + PAYLOAD_WIDTH + SCORE_WIDTH,
   localparam int RSP_TDATA_W  = ((RSP_RAW_W + 7) / 8) * 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // payload, score, index
   input  wire logic [REQ_TDATA_W-1:0]             req_tdata,
   // opcode
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // entry_count, read_payload, read_score
   output logic [RSP_TDATA_W-1:0]                  rsp_tdata,
   // kept, read_valid
   output logic [1:0]                              rsp_tuser,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [tkk_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [tkk_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tkk_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                    csr_pready
);

   tkk_pkg::opcode_type           opcode;
   logic [PAYLOAD_WIDTH-1:0]      item_payload;
   logic signed [SCORE_WIDTH-1:0] item_score;
   logic [tkk_pkg::IDX_W-1:0]     item_index;
   logic                          fire;
   logic                          csr_wr;

   tkk_pkg::store_ctl_type ctl;
   tkk_pkg::store_sts_type sts;
   logic [CNT_W-1:0]              count_next;
   logic [PAYLOAD_WIDTH-1:0]      rd_payload;
   logic signed [SCORE_WIDTH-1:0] rd_score;

   logic [tkk_pkg::CAP_W-1:0]     capacity_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [RSP_TDATA_W-1:0]        rsp_data_ff;
   logic [1:0]                    rsp_user_ff;

   assign opcode       = tkk_pkg::opcode_type'(req_tuser);
   assign item_payload = req_tdata[PAYLOAD_WIDTH-1:0];
   assign item_score   = req_tdata[PAYLOAD_WIDTH +: SCORE_WIDTH];
   assign item_index   = req_tdata[PAYLOAD_WIDTH + SCORE_WIDTH +: tkk_pkg::IDX_W];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;

   assign ctl.fire    = fire;
   assign ctl.is_read = (opcode == tkk_pkg::OP_READ);

   tkk_store #(
      .MAX_ENTRIES   (MAX_ENTRIES),
      .SCORE_WIDTH   (SCORE_WIDTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
      .CNT_W         (CNT_W)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .item_payload (item_payload),
      .item_score   (item_score),
      .item_index   (item_index),
      .capacity     (capacity_ff),
      .sts          (sts),
      .count_next   (count_next),
      .rd_payload   (rd_payload),
      .rd_score     (rd_score)
   );

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[tkk_pkg::CSR_ADDR_W-1:2] == tkk_pkg::REG_CAPACITY)
                       ? tkk_pkg::CSR_DATA_W'(capacity_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= tkk_pkg::CAP_RESET;
      end else if (csr_wr
                   && csr_paddr[tkk_pkg::CSR_ADDR_W-1:2] == tkk_pkg::REG_CAPACITY) begin
         capacity_ff <= csr_pwdata[tkk_pkg::CAP_W-1:0];
      end
   end

   // result register
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= RSP_TDATA_W'({rd_score, rd_payload, count_next});
         rsp_user_ff <= {sts.read_valid, sts.kept};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

@@ design/tkk_store.sv @@
// sorted entry store, worst score at slot 0, with a parallel compare-and-shift insert
// depends on tkk_pkg
`default_nettype none

module tkk_store #(
   parameter int MAX_ENTRIES   = tkk_pkg::MAX_ENTRIES_DEF,
   parameter int SCORE_WIDTH   = tkk_pkg::SCORE_WIDTH_DEF,
   parameter int PAYLOAD_WIDTH = tkk_pkg::PAYLOAD_WIDTH_DEF,
   parameter int CNT_W         = $clog2(MAX_ENTRIES + 1)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire tkk_pkg::store_ctl_type          ctl,
   input  wire logic [PAYLOAD_WIDTH-1:0]        item_payload,
   input  wire logic signed [SCORE_WIDTH-1:0]   item_score,
   input  wire logic [tkk_pkg::IDX_W-1:0]       item_index,
   input  wire logic [tkk_pkg::CAP_W-1:0]       capacity,
   output tkk_pkg::store_sts_type               sts,
   output logic [CNT_W-1:0]                     count_next,
   output logic [PAYLOAD_WIDTH-1:0]             rd_payload,
   output logic signed [SCORE_WIDTH-1:0]        rd_score
);

   localparam int LIM_W = (CNT_W > tkk_pkg::CAP_W) ? CNT_W : tkk_pkg::CAP_W;
   localparam int SEL_W = (CNT_W > tkk_pkg::IDX_W) ? CNT_W : tkk_pkg::IDX_W;

   logic [PAYLOAD_WIDTH-1:0]      pay_ff   [MAX_ENTRIES];
   logic signed [SCORE_WIDTH-1:0] score_ff [MAX_ENTRIES];
   logic [PAYLOAD_WIDTH-1:0]      pay_in   [MAX_ENTRIES];
   logic signed [SCORE_WIDTH-1:0] score_in [MAX_ENTRIES];
   logic [CNT_W-1:0]              held_ff;
   logic [CNT_W-1:0]              held_in;

   logic [MAX_ENTRIES-1:0]        ge;
   logic [MAX_ENTRIES-1:0]        prev_ge;
   logic [MAX_ENTRIES-1:0]        next_ge;
   logic [PAYLOAD_WIDTH-1:0]      prev_pay   [MAX_ENTRIES];
   logic signed [SCORE_WIDTH-1:0] prev_score [MAX_ENTRIES];
   logic [PAYLOAD_WIDTH-1:0]      next_pay   [MAX_ENTRIES];
   logic signed [SCORE_WIDTH-1:0] next_score [MAX_ENTRIES];

   logic             is_insert;
   logic             full;
   logic             better;
   logic             grow;
   logic             swap;
   logic [SEL_W-1:0] index_ext;

   // neighbour views of each slot
   for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_slot
      assign ge[j] = (CNT_W'(j) < held_ff) && (score_ff[j] >= item_score);
      if (j == 0) begin : g_first
         assign prev_ge[j]    = 1'b1;
         assign prev_pay[j]   = pay_ff[j];
         assign prev_score[j] = score_ff[j];
      end else begin : g_mid
         assign prev_ge[j]    = ge[j-1];
         assign prev_pay[j]   = pay_ff[j-1];
         assign prev_score[j] = score_ff[j-1];
      end
      if (j == MAX_ENTRIES - 1) begin : g_last
         assign next_ge[j]    = 1'b0;
         assign next_pay[j]   = pay_ff[j];
         assign next_score[j] = score_ff[j];
      end else begin : g_inner
         assign next_ge[j]    = ge[j+1];
         assign next_pay[j]   = pay_ff[j+1];
         assign next_score[j] = score_ff[j+1];
      end
   end

   assign is_insert = ctl.fire && !ctl.is_read;
   assign full      = (LIM_W'(held_ff) >= LIM_W'(capacity))
                      || (held_ff == CNT_W'(MAX_ENTRIES));
   assign better    = (held_ff != '0) && (item_score < score_ff[0]);
   assign grow      = is_insert && !full;
   assign swap      = is_insert && full && better;
   assign held_in   = grow ? held_ff + CNT_W'(1) : held_ff;
   assign count_next = held_in;
   assign index_ext = SEL_W'(item_index);

   assign sts.kept       = !ctl.is_read && (!full || better);
   assign sts.read_valid = ctl.is_read && (index_ext < SEL_W'(held_ff));

   always_comb begin
      for (int j = 0; j < MAX_ENTRIES; j++) begin
         pay_in[j]   = pay_ff[j];
         score_in[j] = score_ff[j];
         if (grow) begin
            // open a gap behind the entries of equal or higher score
            if (!ge[j]) begin
               if (prev_ge[j]) begin
                  pay_in[j]   = item_payload;
                  score_in[j] = item_score;
               end else begin
                  pay_in[j]   = prev_pay[j];
                  score_in[j] = prev_score[j];
               end
            end
         end else if (swap) begin
            // drop the worst and close up towards slot 0
            if (next_ge[j]) begin
               pay_in[j]   = next_pay[j];
               score_in[j] = next_score[j];
            end else if (ge[j]) begin
               pay_in[j]   = item_payload;
               score_in[j] = item_score;
            end
         end
      end
   end

   always_comb begin
      rd_payload = '0;
      rd_score   = '0;
      for (int j = 0; j < MAX_ENTRIES; j++) begin
         if (ctl.is_read && (CNT_W'(j) < held_ff) && (index_ext == SEL_W'(j))) begin
            rd_payload = rd_payload | pay_ff[j];
            rd_score   = rd_score | score_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (ctl.fire) begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (grow || swap) begin
         for (int j = 0; j < MAX_ENTRIES; j++) begin
            pay_ff[j]   <= pay_in[j];
            score_ff[j] <= score_in[j];
         end
      end
   end

endmodule

`default_nettype wire

@@ design/tkk_checker.sv @@
// port-level checks of the top-k lowest score keeper, bound to the top level
// depends on tkk_pkg and the assertion macro header
`default_nettype none
`include "top_k_lowest_score_keeper_core_defines.svh"

module tkk_checker #(
   parameter int MAX_ENTRIES   = tkk_pkg::MAX_ENTRIES_DEF,
   parameter int SCORE_WIDTH   = tkk_pkg::SCORE_WIDTH_DEF,
   parameter int PAYLOAD_WIDTH = tkk_pkg::PAYLOAD_WIDTH_DEF,
   localparam int CNT_W        = $clog2(MAX_ENTRIES + 1),
   localparam int RSP_RAW_W    = CNT_W + PAYLOAD_WIDTH + SCORE_WIDTH,
   localparam int RSP_TDATA_W  = ((RSP_RAW_W + 7) / 8) * 8
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [1:0]             rsp_tuser
);

   logic [CNT_W-1:0]         count;
   logic [PAYLOAD_WIDTH-1:0] rpay;
   logic [SCORE_WIDTH-1:0]   rscore;

   assign count  = rsp_tdata[CNT_W-1:0];
   assign rpay   = rsp_tdata[CNT_W +: PAYLOAD_WIDTH];
   assign rscore = rsp_tdata[CNT_W + PAYLOAD_WIDTH +: SCORE_WIDTH];

   // a stalled result holds
   `TKK_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // every accepted item shows up as a result in the next cycle
   `TKK_ASSERT_NEXT(a_item_result, req_tvalid && req_tready, rsp_tvalid)

   `TKK_ASSERT_NOW(a_count_max, rsp_tvalid, count <= CNT_W'(MAX_ENTRIES))

   // an insert never reports a read, and a failed read carries zeros
   `TKK_ASSERT_NOW(a_kept_or_read, rsp_tvalid, !(rsp_tuser[0] && rsp_tuser[1]))

   `TKK_ASSERT_NOW(a_read_zero, rsp_tvalid && !rsp_tuser[1], rpay == '0 && rscore == '0)

endmodule

bind top_k_lowest_score_keeper_core tkk_checker #(
   .MAX_ENTRIES   (MAX_ENTRIES),
   .SCORE_WIDTH   (SCORE_WIDTH),
   .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
) u_tkk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
